// ===== src/art_pkg.sv =====
// ----------------------------------------------------------------------------
// art_pkg
// Shared types, codes and defaults for the ACK / retransmit tracker.
// ----------------------------------------------------------------------------
package art_pkg;

   // command codes on the request channel
   localparam logic [1:0] CMD_SEND = 2'd0;
   localparam logic [1:0] CMD_RECV = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_RECV   = 2'd0;
   localparam logic [1:0] KIND_RESEND = 2'd1;
   localparam logic [1:0] KIND_SEND   = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_TIMEOUT  = 2'd0;
   localparam logic [1:0] CSR_MAXRETRY = 2'd1;
   localparam logic [1:0] CSR_NODEID   = 2'd2;

   localparam logic [15:0] RST_TIMEOUT  = 16'd1000;
   localparam logic [7:0]  RST_MAXRETRY = 8'd10;
   localparam logic [7:0]  RST_NODEID   = 8'd0;

   // resends per tick
   localparam int MAX_RESULTS = 16;

   localparam int DEF_PENDING_DEPTH = 16;
   localparam int DEF_SEEN_DEPTH    = 64;
   localparam int DEF_HANDLE_BITS   = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PSCAN,
      ST_SSCAN,
      ST_FINISH,
      ST_TREAD,
      ST_TCHK,
      ST_EMIT
   } state_type;

   // where an accepted request goes first
   typedef enum logic [2:0] {
      RT_NONE,
      RT_PSCAN,
      RT_SSCAN,
      RT_FINISH,
      RT_TICK
   } route_type;

   typedef struct packed {
      logic idle;
      logic p_step;
      logic s_step;
      logic finish;
      logic t_read;
      logic t_chk;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      route_type route;
      logic      req_fire;
      logic      p_last;
      logic      s_done;
      logic      expired;
      logic      have;
      logic      cnt_last;
      logic      out_free;
   } dp_stat_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] signature;
      logic [7:0]  ack_from;
      logic [7:0]  ack_to;
      logic        emit_ack;
      logic        consumed;
      logic [7:0]  resend_handle;
      logic [7:0]  retry_count;
      logic        retry_exceeded;
      logic        table_full;
   } res_type;

endpackage

// ===== src/art_ifs.sv =====
// ----------------------------------------------------------------------------
// art_ifs
// Request, response and register write channels of the tracker.
// ----------------------------------------------------------------------------
interface art_req_if #(parameter int HANDLE_BITS = 8);
   logic                   valid;
   logic                   ready;
   logic [1:0]             command;
   logic                   is_ack;
   logic                   is_terminate;
   logic [15:0]            app_id;
   logic                   sender_empty;
   logic [7:0]             sender_id;
   logic [7:0]             receiver_id;
   logic [30:0]            timestamp;
   logic                   request;
   logic [63:0]            ack_signature;
   logic [HANDLE_BITS-1:0] msg_handle;

   modport source (output valid, command, is_ack, is_terminate, app_id, sender_empty,
                   sender_id, receiver_id, timestamp, request, ack_signature,
                   msg_handle, input ready);
   modport sink   (input valid, command, is_ack, is_terminate, app_id, sender_empty,
                   sender_id, receiver_id, timestamp, request, ack_signature,
                   msg_handle, output ready);
endinterface

interface art_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [63:0] signature;
   logic [7:0]  ack_from;
   logic [7:0]  ack_to;
   logic        emit_ack;
   logic        consumed;
   logic [7:0]  resend_handle;
   logic [7:0]  retry_count;
   logic        retry_exceeded;
   logic        table_full;
   logic        last;

   modport source (output valid, result_kind, signature, ack_from, ack_to, emit_ack,
                   consumed, resend_handle, retry_count, retry_exceeded, table_full,
                   last, input ready);
   modport sink   (input valid, result_kind, signature, ack_from, ack_to, emit_ack,
                   consumed, resend_handle, retry_count, retry_exceeded, table_full,
                   last, output ready);
endinterface

interface art_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  addr;
   logic [15:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// ===== src/ack_retransmit_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// ack_retransmit_tracker_unit
// Pending-ACK tracker with timeout resend and duplicate receive filter.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus takes one request at a time (send, receive or tick); ready is
//   high only while the sequencer is idle. rsp_bus returns results through
//   an output register; last marks the final result of a request. csr_bus
//   writes timeout_ticks, max_retry and my_node_id; it is always ready.
// Sequence:
//   send and ACK receive: one pending-table entry per cycle.
//   data receive: the seen-signature memory is read one entry per cycle.
//   tick: each pending entry is read (subtract and multiply, registered),
//     then compared; up to MAX_RESULTS resends; a tick with no expiry gives none.
//   terminate, ACK send: no table scan; the result is staged and emitted.
// Reset: both valid vectors, the write pointer and the tick counter clear
//   at once; no sweep is needed. A stalled rsp_bus holds its result and
//   holds off further resends of a tick until the output register frees.
// ----------------------------------------------------------------------------
module ack_retransmit_tracker_unit
   import art_pkg::*;
#(
   parameter int PENDING_DEPTH = DEF_PENDING_DEPTH,
   parameter int SEEN_DEPTH    = DEF_SEEN_DEPTH,
   parameter int HANDLE_BITS   = DEF_HANDLE_BITS
)
(
   input  logic      clock,
   input  logic      reset,
   art_req_if.sink   req_bus,
   art_rsp_if.source rsp_bus,
   art_csr_if.sink   csr_bus
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   art_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   art_dp #(
      .PENDING_DEPTH (PENDING_DEPTH),
      .SEEN_DEPTH    (SEEN_DEPTH),
      .HANDLE_BITS   (HANDLE_BITS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .cmd     (cmd),
      .stat    (stat)
   );

endmodule

// ===== src/art_ctrl.sv =====
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer: steps the datapath through table scans and result emission.
// ----------------------------------------------------------------------------
module art_ctrl
   import art_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;

   // tick check stalls when a held resend cannot move to the output yet
   logic t_block;
   assign t_block = stat.expired && stat.have && !stat.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (stat.req_fire) begin
               unique case (stat.route)
                  RT_PSCAN:  state_in = ST_PSCAN;
                  RT_SSCAN:  state_in = ST_SSCAN;
                  RT_FINISH: state_in = ST_FINISH;
                  RT_TICK:   state_in = ST_TREAD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_PSCAN: begin
            if (stat.p_last) state_in = ST_FINISH;
         end
         ST_SSCAN: begin
            if (stat.s_done) state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_EMIT;
         ST_TREAD:  state_in = ST_TCHK;
         ST_TCHK: begin
            priority if (t_block) begin
               state_in = ST_TCHK;
            end else if (stat.expired && stat.cnt_last) begin
               state_in = ST_EMIT;
            end else if (stat.p_last) begin
               state_in = (stat.have || stat.expired) ? ST_EMIT : ST_IDLE;
            end else begin
               state_in = ST_TREAD;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:   cmd.idle   = 1'b1;
         ST_PSCAN:  cmd.p_step = 1'b1;
         ST_SSCAN:  cmd.s_step = 1'b1;
         ST_FINISH: cmd.finish = 1'b1;
         ST_TREAD:  cmd.t_read = 1'b1;
         ST_TCHK:   cmd.t_chk  = !t_block;
         ST_EMIT:   cmd.emit   = stat.out_free;
         default:   cmd = '0;
      endcase
   end

endmodule

// ===== src/art_dp.sv =====
// ----------------------------------------------------------------------------
// art_dp
// Datapath: pending table, seen-signature memory, timers and output register.
// ----------------------------------------------------------------------------
module art_dp
   import art_pkg::*;
#(
   parameter int PENDING_DEPTH = DEF_PENDING_DEPTH,
   parameter int SEEN_DEPTH    = DEF_SEEN_DEPTH,
   parameter int HANDLE_BITS   = DEF_HANDLE_BITS
)
(
   input  logic        clock,
   input  logic        reset,
   art_req_if.sink     req_bus,
   art_rsp_if.source   rsp_bus,
   art_csr_if.sink     csr_bus,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat
);

   localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int SW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
   localparam int CW = $clog2(MAX_RESULTS + 1);

   // configuration
   logic [15:0] timeout_ff;
   logic [7:0]  maxretry_ff;
   logic [7:0]  nodeid_ff;

   // latched request
   logic [1:0]             kind_ff;
   logic                   ack_ff;
   logic                   term_ff;
   logic [63:0]            sig_ff;
   logic [63:0]            key_ff;
   logic [7:0]             from_ff;
   logic [7:0]             to_ff;
   logic [HANDLE_BITS-1:0] hnd_ff;

   // pending table
   logic [PENDING_DEPTH-1:0] p_valid_ff;
   logic [63:0]              p_sig_ff    [PENDING_DEPTH];
   logic [HANDLE_BITS-1:0]   p_handle_ff [PENDING_DEPTH];
   logic [31:0]              p_time_ff   [PENDING_DEPTH];
   logic [7:0]               p_retry_ff  [PENDING_DEPTH];

   // seen set
   logic [63:0]           s_mem [SEEN_DEPTH];
   logic [SEEN_DEPTH-1:0] s_valid_ff;
   logic [SW-1:0]         wp_ff;
   logic [63:0]           rd_ff;
   logic                  rdv_ff;
   logic                  rdp_ff;

   // scan state
   logic [PW-1:0] idx_ff;
   logic [SW:0]   sidx_ff;
   logic          found_ff;
   logic          slot_ok_ff;
   logic [PW-1:0] slot_ff;
   logic          dup_ff;
   logic [31:0]   cur_ff;

   // tick pipeline
   logic [31:0] elapsed_ff;
   logic [24:0] limit_ff;
   logic        tv_ff;
   logic        have_ff;
   logic [CW-1:0] cnt_ff;

   // result staging and output
   res_type res_ff;
   res_type res_in;
   res_type out_ff;
   logic    out_last_ff;
   logic    out_valid_ff;

   route_type   route;
   logic [7:0]  sender;
   logic [63:0] sig_new;
   logic        fire;
   logic        out_free;
   logic        expired;
   logic [7:0]  new_retry;
   logic        p_match;
   logic        s_rd_en;
   logic        send_rec;
   logic        send_full;
   logic        seen_wr;
   logic        t_exp;

   // signature of the incoming request
   assign sender  = req_bus.sender_empty ? nodeid_ff : req_bus.sender_id;
   assign sig_new = {req_bus.app_id, sender, req_bus.receiver_id,
                     req_bus.timestamp, req_bus.request};

   assign req_bus.ready = cmd.idle;
   assign fire          = req_bus.valid && cmd.idle;
   assign csr_bus.ready = 1'b1;
   assign out_free      = !out_valid_ff || rsp_bus.ready;

   // first step for an accepted request
   always_comb begin
      route = RT_NONE;
      unique case (req_bus.command)
         CMD_SEND: route = req_bus.is_ack ? RT_FINISH : RT_PSCAN;
         CMD_RECV: begin
            priority if (req_bus.is_terminate) route = RT_FINISH;
            else if (req_bus.is_ack)           route = RT_PSCAN;
            else                               route = RT_SSCAN;
         end
         CMD_TICK: route = RT_TICK;
         default:  route = RT_NONE;
      endcase
   end

   assign stat.route = route;

   assign expired        = tv_ff && (elapsed_ff > 32'(limit_ff));
   assign new_retry      = (p_retry_ff[idx_ff] == 8'hFF) ? 8'hFF : p_retry_ff[idx_ff] + 8'd1;
   assign p_match        = p_valid_ff[idx_ff] && (p_sig_ff[idx_ff] == key_ff);
   assign s_rd_en        = cmd.s_step && (sidx_ff < (SW+1)'(SEEN_DEPTH));
   assign send_rec       = cmd.finish && (kind_ff == CMD_SEND) && !ack_ff && !found_ff
                           && slot_ok_ff;
   assign send_full      = !ack_ff && !found_ff && !slot_ok_ff;
   assign seen_wr        = cmd.finish && (kind_ff == CMD_RECV) && !term_ff && !ack_ff
                           && !dup_ff;
   assign t_exp          = cmd.t_chk && expired;

   assign stat.req_fire = fire;
   assign stat.p_last   = (idx_ff == PW'(PENDING_DEPTH - 1));
   assign stat.s_done   = (sidx_ff == (SW+1)'(SEEN_DEPTH)) && !rdp_ff;
   assign stat.expired  = expired;
   assign stat.have     = have_ff;
   assign stat.cnt_last = (cnt_ff == CW'(MAX_RESULTS - 1));
   assign stat.out_free = out_free;

   // staged result: verdict or send status, else the resend of the checked entry
   always_comb begin
      res_in = '0;
      if (cmd.finish) begin
         if (kind_ff == CMD_SEND) begin
            res_in.kind       = KIND_SEND;
            res_in.signature  = sig_ff;
            res_in.table_full = send_full;
         end else begin
            res_in.kind = KIND_RECV;
            if (!term_ff) begin
               if (ack_ff) begin
                  res_in.signature = key_ff;
                  res_in.consumed  = 1'b1;
               end else begin
                  res_in.signature = sig_ff;
                  res_in.ack_from  = from_ff;
                  res_in.ack_to    = to_ff;
                  res_in.emit_ack  = 1'b1;
                  res_in.consumed  = dup_ff;
               end
            end
         end
      end else begin
         res_in.kind           = KIND_RESEND;
         res_in.signature      = p_sig_ff[idx_ff];
         res_in.resend_handle  = 8'(p_handle_ff[idx_ff]);
         res_in.retry_count    = new_retry;
         res_in.retry_exceeded = new_retry > maxretry_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= RST_TIMEOUT;
         maxretry_ff  <= RST_MAXRETRY;
         nodeid_ff    <= RST_NODEID;
         p_valid_ff   <= '0;
         s_valid_ff   <= '0;
         wp_ff        <= '0;
         cur_ff       <= '0;
         idx_ff       <= '0;
         sidx_ff      <= '0;
         found_ff     <= 1'b0;
         slot_ok_ff   <= 1'b0;
         slot_ff      <= '0;
         dup_ff       <= 1'b0;
         rdp_ff       <= 1'b0;
         rdv_ff       <= 1'b0;
         tv_ff        <= 1'b0;
         have_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         // register writes
         if (csr_bus.valid) begin
            unique case (csr_bus.addr)
               CSR_TIMEOUT:  timeout_ff  <= csr_bus.data;
               CSR_MAXRETRY: maxretry_ff <= csr_bus.data[7:0];
               CSR_NODEID:   nodeid_ff   <= csr_bus.data[7:0];
               default: ;
            endcase
         end

         // new request
         if (fire) begin
            idx_ff     <= '0;
            sidx_ff    <= '0;
            found_ff   <= 1'b0;
            slot_ok_ff <= 1'b0;
            dup_ff     <= 1'b0;
            rdp_ff     <= 1'b0;
            have_ff    <= 1'b0;
            cnt_ff     <= '0;
            if (req_bus.command == CMD_TICK) cur_ff <= cur_ff + 32'd1;
         end

         // pending scan: duplicate / free slot for a send, clear for an ACK
         if (cmd.p_step) begin
            idx_ff <= idx_ff + PW'(1);
            if (kind_ff == CMD_RECV) begin
               if (p_match) p_valid_ff[idx_ff] <= 1'b0;
            end else begin
               if (p_match) found_ff <= 1'b1;
               if (!p_valid_ff[idx_ff] && !slot_ok_ff) begin
                  slot_ok_ff <= 1'b1;
                  slot_ff    <= idx_ff;
               end
            end
         end

         // seen scan, compare runs in the cycle after the memory read
         if (cmd.s_step) begin
            rdp_ff <= s_rd_en;
            if (s_rd_en) begin
               sidx_ff <= sidx_ff + (SW+1)'(1);
               rdv_ff  <= s_valid_ff[sidx_ff[SW-1:0]];
            end
            if (rdp_ff && rdv_ff && (rd_ff == sig_ff)) dup_ff <= 1'b1;
         end

         if (send_rec) p_valid_ff[slot_ff] <= 1'b1;

         if (seen_wr) begin
            s_valid_ff[wp_ff] <= 1'b1;
            wp_ff <= (wp_ff == SW'(SEEN_DEPTH - 1)) ? '0 : wp_ff + SW'(1);
         end

         if (cmd.t_read) tv_ff <= p_valid_ff[idx_ff];

         // tick check
         if (cmd.t_chk) begin
            idx_ff <= idx_ff + PW'(1);
            if (expired) begin
               have_ff <= 1'b1;
               cnt_ff  <= cnt_ff + CW'(1);
            end
         end

         // output register
         if (cmd.emit || (t_exp && have_ff)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.emit) have_ff <= 1'b0;
      end
   end

   // payload and storage
   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff <= req_bus.command;
         ack_ff  <= req_bus.is_ack;
         term_ff <= req_bus.is_terminate;
         sig_ff  <= sig_new;
         key_ff  <= (req_bus.command == CMD_RECV) ? req_bus.ack_signature : sig_new;
         from_ff <= req_bus.receiver_id;
         to_ff   <= sender;
         hnd_ff  <= req_bus.msg_handle;
      end

      if (s_rd_en) rd_ff <= s_mem[sidx_ff[SW-1:0]];
      if (seen_wr) s_mem[wp_ff] <= sig_ff;

      if (send_rec) begin
         p_sig_ff[slot_ff]    <= sig_ff;
         p_handle_ff[slot_ff] <= hnd_ff;
         p_time_ff[slot_ff]   <= cur_ff;
         p_retry_ff[slot_ff]  <= 8'd0;
      end

      // elapsed time and scaled timeout, registered before the compare
      if (cmd.t_read) begin
         elapsed_ff <= cur_ff - p_time_ff[idx_ff];
         limit_ff   <= timeout_ff * {1'b0, p_retry_ff[idx_ff]} + 25'(timeout_ff);
      end

      // expired entry: count a retry
      if (t_exp) p_retry_ff[idx_ff] <= new_retry;

      // stage the verdict, send status or resend
      if (cmd.finish || t_exp) res_ff <= res_in;

      if (cmd.emit) begin
         out_ff      <= res_ff;
         out_last_ff <= 1'b1;
      end else if (t_exp && have_ff) begin
         out_ff      <= res_ff;
         out_last_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.result_kind    = out_ff.kind;
   assign rsp_bus.signature      = out_ff.signature;
   assign rsp_bus.ack_from       = out_ff.ack_from;
   assign rsp_bus.ack_to         = out_ff.ack_to;
   assign rsp_bus.emit_ack       = out_ff.emit_ack;
   assign rsp_bus.consumed       = out_ff.consumed;
   assign rsp_bus.resend_handle  = out_ff.resend_handle;
   assign rsp_bus.retry_count    = out_ff.retry_count;
   assign rsp_bus.retry_exceeded = out_ff.retry_exceeded;
   assign rsp_bus.table_full     = out_ff.table_full;
   assign rsp_bus.last           = out_last_ff;

endmodule

// ===== src/art_checker.sv =====
// ----------------------------------------------------------------------------
// art_checker
// Port-level checks on the tracker's response channel.
// ----------------------------------------------------------------------------
module art_checker
   import art_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [63:0] rsp_signature,
   input logic        rsp_emit_ack,
   input logic [7:0]  rsp_retry_count,
   input logic        rsp_table_full
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_signature) && $stable(rsp_kind))
      else $error("stalled response changed");

   // ACK emission only on receive verdicts
   a_emit_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_emit_ack |-> rsp_kind == KIND_RECV)
      else $error("emit_ack on non-receive result");

   // a resend always carries a counted retry
   a_resend_retry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_RESEND |-> rsp_retry_count != 8'd0)
      else $error("resend with zero retry count");

   // table full is only a send status
   a_full_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_kind == KIND_SEND)
      else $error("table_full on non-send result");

endmodule

bind ack_retransmit_tracker_unit art_checker u_art_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_kind        (rsp_bus.result_kind),
   .rsp_signature   (rsp_bus.signature),
   .rsp_emit_ack    (rsp_bus.emit_ack),
   .rsp_retry_count (rsp_bus.retry_count),
   .rsp_table_full  (rsp_bus.table_full)
);
